// ===== hdl/text_mode_terminal_writer_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Text mode terminal writer: assertion macros
// Shared concurrent assertion forms, same-cycle and next-cycle implication.
// ----------------------------------------------------------------------------
`ifndef TEXT_MODE_TERMINAL_WRITER_UNIT_MACROS_SVH
`define TEXT_MODE_TERMINAL_WRITER_UNIT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define TTW_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define TTW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/ttw_pkg.sv =====
// ----------------------------------------------------------------------------
// ttw_pkg
// Item types, character codes and action codes of the text terminal writer.
// ----------------------------------------------------------------------------
package ttw_pkg;

    localparam int ACTION_W     = 2;
    localparam int CODE_W       = 8;
    localparam int IDX_W        = 11;
    localparam int CELL_W       = 16;
    localparam int CUR_ROW_W    = 5;
    localparam int CUR_COL_W    = 7;
    localparam int COLOR_W      = 8;

    localparam logic [ACTION_W-1:0] ACT_PUT   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_READ  = 2'd2;

    localparam logic [1:0] REG_TEXT_COLOR = 2'd0;

    localparam logic [CODE_W-1:0]  CODE_RETURN      = 8'd13;
    localparam logic [CODE_W-1:0]  CODE_LINEFEED    = 8'd10;
    localparam logic [CODE_W-1:0]  CODE_SPACE       = 8'd32;
    localparam logic [COLOR_W-1:0] TEXT_COLOR_RESET = 8'd2;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [CODE_W-1:0]   char_code;
        logic [IDX_W-1:0]    cell_index;
    } t_in_item;

    typedef struct packed {
        logic [CELL_W-1:0]    cell_value;
        logic [CUR_ROW_W-1:0] cursor_row;
        logic [CUR_COL_W-1:0] cursor_column;
    } t_out_item;

endpackage

// ===== hdl/ttw_ram.sv =====
// ----------------------------------------------------------------------------
// ttw_ram
// Screen cell store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ttw_ram #(
    parameter int DEPTH  = 2000,
    parameter int ADDR_W = 11,
    parameter int DATA_W = 16
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/ttw_alu.sv =====
// ----------------------------------------------------------------------------
// ttw_alu
// Shared add and limit compare used for cursor steps, sweeps and range checks.
// ----------------------------------------------------------------------------
module ttw_alu #(
    parameter int W = 12
) (
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    input  logic [W-1:0] i_lim,
    output logic [W-1:0] o_sum,
    output logic         o_at_lim
);

    assign o_sum    = i_a + i_b;
    assign o_at_lim = (o_sum >= i_lim);

endmodule

// ===== hdl/text_mode_terminal_writer_unit.sv =====
// ----------------------------------------------------------------------------
// text_mode_terminal_writer_unit
// Character cell screen writer: put, clear and read on a cell store with a
// cursor, configured through an APB-style register port.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                     payload
//  in        input      i_in_valid / o_in_ready       i_in_item  (t_in_item)
//  out       output     o_out_valid / i_out_ready     o_out_item (t_out_item)
//  config    input      psel penable pwrite pready    paddr pwdata / prdata
//
//  Each item is decoded, then passes its put, line feed, copy or fill states;
//  a line feed on the last row copies (ROWS-1)*COLUMNS cells up one row and
//  blanks COLUMNS cells. Clear blanks ROWS*COLUMNS cells; a read out of range
//  skips the store. Copies read, then write, each cell on the single read port.
//  Synchronous active-low reset; cursor at 0,0, color 2; store undefined.
//  A new item is taken while a result waits; it stalls before delivery.
// ----------------------------------------------------------------------------
`include "text_mode_terminal_writer_unit_macros.svh"

module text_mode_terminal_writer_unit
    import ttw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_item,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CELL_COUNT   = ROWS * COLUMNS;
    localparam int SCROLL_CELLS = (ROWS - 1) * COLUMNS;
    localparam int ADDR_W       = $clog2(CELL_COUNT);
    localparam int AW1          = ADDR_W + 1;
    localparam int ROW_W        = $clog2(ROWS);
    localparam int COL_W        = $clog2(COLUMNS);
    localparam int ALU_W        = ((ADDR_W > IDX_W) ? ADDR_W : IDX_W) + 1;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DEC  = 4'd1;
    localparam logic [3:0] S_PUT  = 4'd2;
    localparam logic [3:0] S_LF   = 4'd3;
    localparam logic [3:0] S_SCRD = 4'd4;
    localparam logic [3:0] S_SCWR = 4'd5;
    localparam logic [3:0] S_FILL = 4'd6;
    localparam logic [3:0] S_RDW  = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    logic [3:0]          r_state, n_state;
    logic [ACTION_W-1:0] r_act, n_act;
    logic [CODE_W-1:0]   r_code, n_code;
    logic [IDX_W-1:0]    r_index, n_index;
    logic [ROW_W-1:0]    r_row, n_row;
    logic [COL_W-1:0]    r_col, n_col;
    logic [ADDR_W-1:0]   r_ptr, n_ptr;
    logic [CELL_W-1:0]   r_value, n_value;
    logic                r_out_valid, n_out_valid;
    t_out_item           r_out, n_out;
    logic [COLOR_W-1:0]  r_color, n_color;

    logic [ALU_W-1:0]    w_a, w_b, w_lim, w_sum;
    logic                w_at_lim;
    logic                w_we, w_re;
    logic [ADDR_W-1:0]   w_waddr, w_raddr, w_put_addr;
    logic [CELL_W-1:0]   w_wdata, w_rdata;
    logic                w_in_acc, w_cfg_wr;

    ttw_alu #(
        .W (ALU_W)
    ) u_alu (
        .i_a      (w_a),
        .i_b      (w_b),
        .i_lim    (w_lim),
        .o_sum    (w_sum),
        .o_at_lim (w_at_lim)
    );

    ttw_ram #(
        .DEPTH  (CELL_COUNT),
        .ADDR_W (ADDR_W),
        .DATA_W (CELL_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign pready      = 1'b1;
    assign w_cfg_wr    = psel && penable && pwrite && pready && (paddr == REG_TEXT_COLOR);
    assign w_put_addr  = ADDR_W'(AW1'(r_row) * AW1'(COLUMNS) + AW1'(r_col));

    always_comb begin
        prdata = '0;
        if (paddr == REG_TEXT_COLOR) begin
            prdata[COLOR_W-1:0] = r_color;
        end
    end

    always_comb begin
        w_a   = '0;
        w_b   = '0;
        w_lim = '0;
        case (r_state)
            S_DEC: begin
                w_a   = ALU_W'(r_index);
                w_lim = ALU_W'(CELL_COUNT);
            end
            S_PUT: begin
                w_a   = ALU_W'(r_col);
                w_b   = ALU_W'(1);
                w_lim = ALU_W'(COLUMNS);
            end
            S_LF: begin
                w_a   = ALU_W'(r_row);
                w_b   = ALU_W'(1);
                w_lim = ALU_W'(ROWS);
            end
            S_SCRD: begin
                w_a   = ALU_W'(r_ptr);
                w_b   = ALU_W'(COLUMNS);
                w_lim = ALU_W'(CELL_COUNT);
            end
            S_SCWR: begin
                w_a   = ALU_W'(r_ptr);
                w_b   = ALU_W'(1);
                w_lim = ALU_W'(SCROLL_CELLS);
            end
            S_FILL: begin
                w_a   = ALU_W'(r_ptr);
                w_b   = ALU_W'(1);
                w_lim = ALU_W'(CELL_COUNT);
            end
            default: begin
                w_a   = '0;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_act       = r_act;
        n_code      = r_code;
        n_index     = r_index;
        n_row       = r_row;
        n_col       = r_col;
        n_ptr       = r_ptr;
        n_value     = r_value;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        n_color     = w_cfg_wr ? pwdata[COLOR_W-1:0] : r_color;
        w_we        = 1'b0;
        w_waddr     = r_ptr;
        w_wdata     = {r_color, CODE_SPACE};
        w_re        = 1'b0;
        w_raddr     = w_sum[ADDR_W-1:0];

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_act   = i_in_item.action;
                    n_code  = i_in_item.char_code;
                    n_index = i_in_item.cell_index;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_value = '0;
                case (r_act)
                    ACT_PUT: begin
                        if (r_code == CODE_RETURN) begin
                            n_col   = '0;
                            n_state = S_DONE;
                        end else if (r_code == CODE_LINEFEED) begin
                            n_state = S_LF;
                        end else begin
                            n_state = S_PUT;
                        end
                    end
                    ACT_CLEAR: begin
                        n_ptr   = '0;
                        n_state = S_FILL;
                    end
                    ACT_READ: begin
                        if (w_at_lim) begin
                            n_state = S_DONE;
                        end else begin
                            w_re    = 1'b1;
                            n_state = S_RDW;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_PUT: begin
                w_we    = 1'b1;
                w_waddr = w_put_addr;
                w_wdata = {r_color, r_code};
                if (w_at_lim) begin
                    n_col   = '0;
                    n_state = S_LF;
                end else begin
                    n_col   = w_sum[COL_W-1:0];
                    n_state = S_DONE;
                end
            end
            S_LF: begin
                if (w_at_lim) begin
                    n_ptr   = '0;
                    n_state = S_SCRD;
                end else begin
                    n_row   = w_sum[ROW_W-1:0];
                    n_state = S_DONE;
                end
            end
            S_SCRD: begin
                w_re    = 1'b1;
                n_state = S_SCWR;
            end
            S_SCWR: begin
                w_we    = 1'b1;
                w_wdata = w_rdata;
                n_ptr   = w_sum[ADDR_W-1:0];
                n_state = w_at_lim ? S_FILL : S_SCRD;
            end
            S_FILL: begin
                w_we    = 1'b1;
                n_ptr   = w_sum[ADDR_W-1:0];
                if (w_at_lim) begin
                    n_state = S_DONE;
                end
            end
            S_RDW: begin
                n_value = w_rdata;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out.cell_value    = r_value;
                    n_out.cursor_row    = CUR_ROW_W'(r_row);
                    n_out.cursor_column = CUR_COL_W'(r_col);
                    n_out_valid         = 1'b1;
                    n_state             = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_row       <= '0;
            r_col       <= '0;
            r_out_valid <= 1'b0;
            r_color     <= TEXT_COLOR_RESET;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_col       <= n_col;
            r_out_valid <= n_out_valid;
            r_color     <= n_color;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act   <= n_act;
        r_code  <= n_code;
        r_index <= n_index;
        r_ptr   <= n_ptr;
        r_value <= n_value;
        r_out   <= n_out;
    end

    `TTW_ASSERT_NOW(a_cursor_range, i_clk, i_rst_n, 1'b1, (r_row < ROWS) && (r_col < COLUMNS), "cursor out of range")
    `TTW_ASSERT_NOW(a_idle_no_write, i_clk, i_rst_n, r_state == S_IDLE, !w_we, "store written while idle")
    `TTW_ASSERT_NEXT(a_accept_decode, i_clk, i_rst_n, w_in_acc, r_state == S_DEC, "accepted item not decoded")
    `TTW_ASSERT_NOW(a_result_from_done, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state == S_DONE), "result without completion")

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// Text mode terminal writer testbench
// Drives put, clear, read and unused actions through the valid/ready item
// channel and sets the text color over the register port. A screen image
// with its own cursor predicts every reply; replies are checked field by
// field in order. Covers wrap, scroll on the last row, random text with
// sender gaps and receiver stalls, and one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench
    import ttw_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int COLS  = 80;
    localparam int ROWS  = 25;
    localparam int CELLS = COLS * ROWS;

    localparam logic [ACTION_W-1:0] ACT_UNUSED     = 2'd3;

    localparam int HOLD_OFF_CYCLES = 300;
    localparam int TIMEOUT_NS      = 100_000_000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in_item    in_item;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out_item   out_item;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    text_mode_terminal_writer_unit #(
        .COLUMNS (COLS),
        .ROWS    (ROWS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // screen image and cursor
    logic [CELL_W-1:0]  screen_img [0:CELLS-1];
    int unsigned        cur_row;
    int unsigned        cur_col;
    logic [COLOR_W-1:0] text_color;

    t_out_item terminal_replies[$];

    int unsigned fail_count;
    int unsigned items_sent;
    int unsigned replies_checked;
    int unsigned scroll_count;
    int unsigned clear_count;
    int unsigned read_count;
    int unsigned colors_used;
    int unsigned burst_left;
    bit          gaps_enabled;
    bit          hold_off_req;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("TEST FAILED");
        $finish;
    end

    function automatic t_in_item terminal_item(input logic [ACTION_W-1:0] action,
                                               input logic [CODE_W-1:0] code,
                                               input logic [IDX_W-1:0] idx);
        t_in_item it;
        it.action     = action;
        it.char_code  = code;
        it.cell_index = idx;
        return it;
    endfunction

    function automatic void line_down();
        int unsigned k;
        if (cur_row + 1 < ROWS) begin
            cur_row++;
            return;
        end
        for (k = 0; k < CELLS - COLS; k++) screen_img[k] = screen_img[k + COLS];
        for (k = CELLS - COLS; k < CELLS; k++) screen_img[k] = {text_color, CODE_SPACE};
        scroll_count++;
    endfunction

    function automatic t_out_item screen_step(input t_in_item it);
        t_out_item   r;
        int unsigned k;
        r = '0;
        case (it.action)
            ACT_PUT: begin
                if (it.char_code == CODE_RETURN) begin
                    cur_col = 0;
                end else if (it.char_code == CODE_LINEFEED) begin
                    line_down();
                end else begin
                    screen_img[cur_row * COLS + cur_col] = {text_color, it.char_code};
                    cur_col++;
                    if (cur_col >= COLS) begin
                        cur_col = 0;
                        line_down();
                    end
                end
            end
            ACT_CLEAR: begin
                for (k = 0; k < CELLS; k++) screen_img[k] = {text_color, CODE_SPACE};
                clear_count++;
            end
            ACT_READ: begin
                if (it.cell_index < CELLS) r.cell_value = screen_img[it.cell_index];
                read_count++;
            end
            default: ;
        endcase
        r.cursor_row    = CUR_ROW_W'(cur_row);
        r.cursor_column = CUR_COL_W'(cur_col);
        return r;
    endfunction

    task automatic check_field(input string what, input logic [CELL_W-1:0] want,
                               input logic [CELL_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : check_replies
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (terminal_replies.size() == 0) begin
                $display("%0t: unexpected reply, expected none, got %h", $time, out_item);
                fail_count++;
            end else begin
                want = terminal_replies.pop_front();
                check_field("cell_value", want.cell_value, out_item.cell_value);
                check_field("cursor_row", CELL_W'(want.cursor_row), CELL_W'(out_item.cursor_row));
                check_field("cursor_column", CELL_W'(want.cursor_column),
                            CELL_W'(out_item.cursor_column));
                replies_checked++;
            end
        end
    end

    // receiver: rotating stall pattern, or one long hold-off on request
    initial begin : out_ready_pattern
        int unsigned stall_tick;
        stall_tick  = 0;
        i_out_ready = 1'b1;
        forever begin
            @(negedge i_clk);
            stall_tick++;
            if (hold_off_req) begin
                i_out_ready = 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge i_clk);
                hold_off_req = 1'b0;
            end else begin
                case ((stall_tick / 97) % 4)
                    0: i_out_ready = 1'b1;
                    1: i_out_ready = 1'($urandom_range(0, 1));
                    2: i_out_ready = ($urandom_range(0, 3) == 0);
                    default: i_out_ready = ((stall_tick % 7) < 4);
                endcase
            end
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    // with valid still high
    task automatic push_item(input t_in_item it);
        if (gaps_enabled) begin
            if (burst_left == 0) begin
                i_in_valid = 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
                burst_left = $urandom_range(1, 24);
            end
            burst_left--;
        end
        in_item    = it;
        i_in_valid = 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        terminal_replies.push_back(screen_step(it));
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        i_in_valid = 1'b0;
        while (terminal_replies.size() != 0) @(negedge i_clk);
    endtask

    task automatic check_text_color();
        logic [31:0] got;
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = REG_TEXT_COLOR;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        got = prdata;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        if (got[COLOR_W-1:0] !== text_color) begin
            $display("%0t: text_color readback mismatch, expected %h, got %h",
                     $time, text_color, got[COLOR_W-1:0]);
            fail_count++;
        end
    endtask

    task automatic set_text_color(input logic [COLOR_W-1:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = REG_TEXT_COLOR;
        pwdata  = {24'($urandom), value};
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        text_color = value;
        colors_used++;
        check_text_color();
    endtask

    task automatic type_line(input int unsigned len);
        int unsigned        k;
        logic [CODE_W-1:0]  code;
        for (k = 0; k < len; k++) begin
            if ($urandom_range(0, 99) < 12)
                push_item(terminal_item(ACT_READ, 8'($urandom),
                                        11'(cur_row * COLS + $urandom_range(0, COLS - 1))));
            if ($urandom_range(0, 99) < 5) code = 8'($urandom);
            else code = 8'($urandom_range(33, 126));
            push_item(terminal_item(ACT_PUT, code, 11'($urandom)));
        end
        if ($urandom_range(0, 1)) push_item(terminal_item(ACT_PUT, CODE_RETURN, 11'($urandom)));
        push_item(terminal_item(ACT_PUT, CODE_LINEFEED, 11'($urandom)));
    endtask

    task automatic test_register_port();
        check_text_color();
        set_text_color(8'hFF);
        set_text_color(8'h00);
        set_text_color(TEXT_COLOR_RESET);
    endtask

    task automatic test_directed_actions();
        push_item(terminal_item(ACT_UNUSED, 8'h00, 11'h000));
        push_item(terminal_item(ACT_CLEAR, 8'hFF, 11'h7FF));
        push_item(terminal_item(ACT_PUT, 8'h00, 11'h000));
        push_item(terminal_item(ACT_PUT, 8'hFF, 11'h7FF));
        push_item(terminal_item(ACT_PUT, CODE_RETURN, 11'h000));
        push_item(terminal_item(ACT_PUT, 8'h41, 11'h000));
        push_item(terminal_item(ACT_PUT, CODE_LINEFEED, 11'h000));
        push_item(terminal_item(ACT_PUT, CODE_SPACE, 11'h000));
        push_item(terminal_item(ACT_READ, 8'h00, 11'd0));
        push_item(terminal_item(ACT_READ, 8'h00, 11'd1));
        push_item(terminal_item(ACT_READ, 8'h00, 11'd2));
        push_item(terminal_item(ACT_READ, 8'h00, 11'(COLS)));
        push_item(terminal_item(ACT_READ, 8'h00, 11'(CELLS - 1)));
        push_item(terminal_item(ACT_READ, 8'h00, 11'(CELLS)));
        push_item(terminal_item(ACT_READ, 8'hFF, 11'h7FF));
        push_item(terminal_item(ACT_UNUSED, 8'hFF, 11'h7FF));
        push_item(terminal_item(ACT_READ, CODE_LINEFEED, 11'd1));
        wait_idle();
    endtask

    task automatic test_bottom_row_scroll();
        int unsigned k;
        while (cur_row < ROWS - 1)
            push_item(terminal_item(ACT_PUT, CODE_LINEFEED, 11'($urandom)));
        for (k = 0; k < 6; k++)
            push_item(terminal_item(ACT_PUT, 8'($urandom_range(33, 126)), 11'h000));
        push_item(terminal_item(ACT_PUT, CODE_LINEFEED, 11'h000));
        push_item(terminal_item(ACT_PUT, CODE_RETURN, 11'h000));
        push_item(terminal_item(ACT_PUT, CODE_LINEFEED, 11'h000));
        for (k = 0; k < 3; k++) begin
            push_item(terminal_item(ACT_READ, 8'h00, 11'((ROWS - 2) * COLS + 6 + k)));
            push_item(terminal_item(ACT_READ, 8'h00, 11'((ROWS - 1) * COLS + k)));
        end
        push_item(terminal_item(ACT_READ, 8'h00, 11'd0));
        wait_idle();
    endtask

    task automatic test_output_hold_off();
        int unsigned k;
        gaps_enabled = 1'b0;
        hold_off_req = 1'b1;
        for (k = 0; k < 16; k++)
            push_item(terminal_item(ACT_PUT, 8'($urandom_range(33, 126)), 11'($urandom)));
        push_item(terminal_item(ACT_READ, 8'h00, 11'((ROWS - 1) * COLS + cur_col - 1)));
        wait_idle();
    endtask

    task automatic test_random_text();
        int unsigned phase;
        int unsigned target;
        int unsigned roll;
        int unsigned k;
        for (phase = 0; phase < 4; phase++) begin
            wait_idle();
            case (phase)
                0: set_text_color(8'h00);
                1: set_text_color(8'hFF);
                default: set_text_color(8'($urandom));
            endcase
            gaps_enabled = (phase != 1);
            burst_left   = 0;
            push_item(terminal_item(ACT_CLEAR, 8'($urandom), 11'($urandom)));
            target = items_sent + 130;
            while (items_sent < target) begin
                roll = $urandom_range(0, 99);
                if (roll < 70) begin
                    type_line($urandom_range(0, 30));
                end else if (roll < 78) begin
                    type_line($urandom_range(60, 170));
                end else if (roll < 90) begin
                    for (k = $urandom_range(1, 6); k > 0; k--)
                        push_item(terminal_item(ACT_READ, 8'($urandom),
                                                11'($urandom_range(0, 2047))));
                end else if (roll < 94) begin
                    push_item(terminal_item(ACT_UNUSED, 8'($urandom), 11'($urandom)));
                end else if (roll < 96) begin
                    push_item(terminal_item(ACT_CLEAR, 8'($urandom), 11'($urandom)));
                end else begin
                    push_item(terminal_item(2'($urandom_range(0, 3)), 8'($urandom),
                                            11'($urandom)));
                end
            end
        end
        wait_idle();
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        in_item      = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = REG_TEXT_COLOR;
        pwdata       = '0;
        cur_row      = 0;
        cur_col      = 0;
        text_color   = TEXT_COLOR_RESET;
        gaps_enabled = 1'b1;
        hold_off_req = 1'b0;
        burst_left   = 0;
        for (int k = 0; k < CELLS; k++) screen_img[k] = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_register_port();
        test_directed_actions();
        test_bottom_row_scroll();
        test_output_hold_off();
        test_random_text();

        wait_idle();
        repeat (20) @(posedge i_clk);
        $display("Sent %0d items: %0d reads, %0d clears, %0d scrolls, %0d color settings.",
                 items_sent, read_count, clear_count, scroll_count, colors_used);
        $display("Checked %0d replies, including a %0d-cycle receiver hold-off.",
                 replies_checked, HOLD_OFF_CYCLES);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/ttw_pkg.sv
hdl/ttw_ram.sv
hdl/ttw_alu.sv
hdl/text_mode_terminal_writer_unit.sv
dv/testbench.sv
